FILE: hdl/nec_tx_pkg.sv
// Package: shared types, codes and segment timing for the NEC IR transmitter.
package nec_tx_pkg;

    localparam int REM_W  = 14;
    localparam int BPOS_W = 6;
    localparam int LVL_W  = 8;
    localparam int DATA_BITS = 32;

    localparam logic [REM_W-1:0] MARK_US         = REM_W'(562);
    localparam logic [REM_W-1:0] ONE_SPACE_US    = REM_W'(1688);
    localparam logic [REM_W-1:0] ZERO_SPACE_US   = REM_W'(563);
    localparam logic [REM_W-1:0] LONG_LEADER_US  = REM_W'(9000);
    localparam logic [REM_W-1:0] SHORT_LEADER_US = REM_W'(4500);
    localparam logic [REM_W-1:0] LEADER_SPACE_US = REM_W'(4500);

    localparam logic [LVL_W-1:0] CARRIER_TOP_RESET = LVL_W'(26);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ON    = 2'd2;
    localparam logic [1:0] OP_OFF   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP_MARK,
        PH_STOP_SPACE
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       long_leader;
        logic [7:0] address_low;
        logic [7:0] address_high;
        logic [7:0] command;
    } item_t;

    typedef struct packed {
        logic [LVL_W-1:0] drive_level;
        logic             busy_res;
    } result_t;

endpackage

FILE: hdl/nec_tx_chan_if.sv
// Interface: valid/ready channel with a typed payload.
interface nec_tx_chan_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/nec_tx_top.sv
// NEC IR frame transmitter top level.
// Takes one item per clock: a microsecond tick, a frame start, or a manual on/off, and
// returns one result per item giving the carrier compare level now in force and the busy
// flag. An item goes through a one-entry input register, then the segment timer and phase
// sequencer update state and load the result register in the same cycle; with a ready
// consumer, the sustained rate is one item per cycle. A consumer stall holds the result
// register and backs up to the input through the ready path, so nothing is dropped.
// Start, manual on and manual off are ignored while a frame is being sent. The carrier
// register is to be written through its own channel only while no item is in flight; the
// block does not enforce it. New values apply from the next mark segment or manual command.
module nec_ir_frame_transmitter_top (
    input  logic          clk,
    input  logic          rst_n,
    nec_tx_chan_if.sink   item,
    nec_tx_chan_if.sink   cfg,
    nec_tx_chan_if.source result
);
    import nec_tx_pkg::*;

    nec_tx_chan_if #(.payload_t(nec_tx_pkg::item_t)) staged ();

    nec_tx_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (item),
        .down  (staged)
    );

    nec_tx_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (staged),
        .cfg    (cfg),
        .result (result)
    );

endmodule

FILE: hdl/nec_tx_in_stage.sv
// Input register stage: holds one accepted item for the frame engine.
module nec_tx_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    nec_tx_chan_if.sink   up,
    nec_tx_chan_if.source down
);
    import nec_tx_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;

    assign up.ready   = !valid_reg || down.ready;
    assign down.valid = valid_reg;
    assign down.data  = data_reg;

    assign valid_next = up.ready ? up.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            data_reg <= up.data;
        end
    end

endmodule

FILE: hdl/nec_tx_engine.sv
// Frame engine: segment timer, phase sequencer, carrier register and result register.
module nec_tx_engine (
    input  logic          clk,
    input  logic          rst_n,
    nec_tx_chan_if.sink   item,
    nec_tx_chan_if.sink   cfg,
    nec_tx_chan_if.source result
);
    import nec_tx_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [REM_W-1:0]  rem_reg, rem_next, rem_dec;
    logic [BPOS_W-1:0] bpos_reg, bpos_next, bpos_inc;
    logic [DATA_BITS-1:0] frame_reg, frame_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  top_reg, mark_level;
    logic              busy;
    logic              take;
    logic              cur_bit;
    logic              res_valid_reg, res_valid_next;
    result_t           res_data_reg;
    item_t             it;

    assign it         = item.data;
    assign item.ready = !res_valid_reg || result.ready;
    assign take       = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign busy       = (phase_reg != PH_IDLE);
    assign mark_level = {1'b0, top_reg[LVL_W-1:1]};
    assign rem_dec    = (rem_reg != '0) ? rem_reg - REM_W'(1) : '0;
    assign bpos_inc   = bpos_reg + BPOS_W'(1);
    assign cur_bit    = frame_reg[bpos_reg[4:0]];

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        bpos_next  = bpos_reg;
        frame_next = frame_reg;
        if (take)
        begin
            if (it.operation == OP_TICK)
            begin
                if (busy)
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        // segment over: next one starts on this same tick
                        case (phase_reg)
                            PH_LEAD_MARK:
                            begin
                                phase_next = PH_LEAD_SPACE;
                                rem_next   = LEADER_SPACE_US;
                            end
                            PH_LEAD_SPACE:
                            begin
                                bpos_next  = '0;
                                phase_next = PH_BIT_MARK;
                                rem_next   = MARK_US;
                            end
                            PH_BIT_MARK:
                            begin
                                phase_next = PH_BIT_SPACE;
                                rem_next   = cur_bit ? ONE_SPACE_US : ZERO_SPACE_US;
                            end
                            PH_BIT_SPACE:
                            begin
                                bpos_next  = bpos_inc;
                                phase_next = bpos_inc[5] ? PH_STOP_MARK : PH_BIT_MARK;
                                rem_next   = MARK_US;
                            end
                            PH_STOP_MARK:
                            begin
                                phase_next = PH_STOP_SPACE;
                                rem_next   = ONE_SPACE_US;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                rem_next   = '0;
                            end
                        endcase
                    end
                end
            end
            else if (!busy)
            begin
                case (it.operation)
                    OP_START:
                    begin
                        frame_next = {~it.command, it.command, it.address_high, it.address_low};
                        bpos_next  = '0;
                        phase_next = PH_LEAD_MARK;
                        rem_next   = it.long_leader ? LONG_LEADER_US : SHORT_LEADER_US;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        level_next = level_reg;
        if (take)
        begin
            if (it.operation == OP_TICK)
            begin
                // a new segment opens at its own level: marks at top/2, spaces and idle dark
                if (busy && rem_dec == '0)
                begin
                    if (phase_next inside {PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK})
                        level_next = mark_level;
                    else
                        level_next = '0;
                end
            end
            else if (!busy)
            begin
                case (it.operation)
                    OP_START: level_next = mark_level;
                    OP_ON:    level_next = top_reg;
                    OP_OFF:   level_next = '0;
                    default:  level_next = level_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            bpos_reg      <= '0;
            frame_reg     <= '0;
            level_reg     <= '0;
            top_reg       <= CARRIER_TOP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            bpos_reg      <= bpos_next;
            frame_reg     <= frame_next;
            level_reg     <= level_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                top_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_data_reg.drive_level <= level_next;
            res_data_reg.busy_res    <= (phase_next != PH_IDLE);
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    a_idle_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (rem_reg == '0))
        else $error("idle with time left in segment");

    a_space_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD_SPACE || phase_reg == PH_BIT_SPACE ||
         phase_reg == PH_STOP_SPACE) |-> (level_reg == '0))
        else $error("nonzero level during a space");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BIT_MARK || phase_reg == PH_BIT_SPACE) |-> !bpos_reg[5])
        else $error("data bit index out of range");

    a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rem_reg != '0))
        else $error("active segment with zero time left");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (result.valid && result.data.busy_res == (phase_reg != PH_IDLE)))
        else $error("result does not match updated state");

endmodule

FILE: sim/tb.sv
// Testbench for the NEC IR frame transmitter: frame start, manual levels and carrier settings.
module tb;
    import nec_tx_pkg::*;

    class nec_frame_scoreboard;
        logic [LVL_W-1:0]  carrier_top;
        phase_t            seg_phase;
        logic [REM_W-1:0]  remaining_us;
        logic [BPOS_W-1:0] bit_pos;
        logic [31:0]       frame_bits;
        logic [LVL_W-1:0]  level_now;
        result_t           pending_levels[$];
        int                errors;

        function new();
            carrier_top  = CARRIER_TOP_RESET;
            seg_phase    = PH_IDLE;
            remaining_us = '0;
            bit_pos      = '0;
            frame_bits   = '0;
            level_now    = '0;
            errors       = 0;
        endfunction

        function logic [LVL_W-1:0] mark_level();
            return carrier_top >> 1;
        endfunction

        function void enter(phase_t ph, logic [REM_W-1:0] dur, logic [LVL_W-1:0] lvl);
            seg_phase    = ph;
            remaining_us = dur;
            level_now    = lvl;
        endfunction

        // next segment starts on the tick that ends the current one
        function void next_segment();
            case (seg_phase)
                PH_LEAD_MARK:
                    enter(PH_LEAD_SPACE, LEADER_SPACE_US, '0);
                PH_LEAD_SPACE:
                begin
                    bit_pos = '0;
                    enter(PH_BIT_MARK, MARK_US, mark_level());
                end
                PH_BIT_MARK:
                    enter(PH_BIT_SPACE,
                          frame_bits[bit_pos[4:0]] ? ONE_SPACE_US : ZERO_SPACE_US, '0);
                PH_BIT_SPACE:
                begin
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos >= DATA_BITS)
                        enter(PH_STOP_MARK, MARK_US, mark_level());
                    else
                        enter(PH_BIT_MARK, MARK_US, mark_level());
                end
                PH_STOP_MARK:
                    enter(PH_STOP_SPACE, ONE_SPACE_US, '0);
                default:
                    enter(PH_IDLE, '0, '0);
            endcase
        endfunction

        function void note_item(item_t it);
            logic    busy;
            result_t r;
            busy = (seg_phase != PH_IDLE);
            if (it.operation == OP_TICK)
            begin
                if (busy)
                begin
                    if (remaining_us != 0)
                        remaining_us = remaining_us - 1'b1;
                    if (remaining_us == 0)
                        next_segment();
                end
            end
            else if (!busy)
            begin
                case (it.operation)
                    OP_START:
                    begin
                        frame_bits = {~it.command, it.command, it.address_high, it.address_low};
                        bit_pos    = '0;
                        enter(PH_LEAD_MARK, it.long_leader ? LONG_LEADER_US : SHORT_LEADER_US,
                              mark_level());
                    end
                    OP_ON:
                        level_now = carrier_top;
                    OP_OFF:
                        level_now = '0;
                    default:
                        ;
                endcase
            end
            r.drive_level = level_now;
            r.busy_res    = (seg_phase != PH_IDLE);
            pending_levels.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_levels.size() == 0)
            begin
                report($sformatf("unexpected result level %0d busy %0b",
                                 got.drive_level, got.busy_res));
                return;
            end
            want = pending_levels.pop_front();
            if (got.drive_level !== want.drive_level)
                report($sformatf("drive_level %0d, want %0d", got.drive_level, want.drive_level));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %0b, want %0b", got.busy_res, want.busy_res));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   recv_stall_pct;

    nec_frame_scoreboard sb = new();

    nec_tx_chan_if #(.payload_t(item_t))            item_ch ();
    nec_tx_chan_if #(.payload_t(logic [LVL_W-1:0])) cfg_ch ();
    nec_tx_chan_if #(.payload_t(result_t))          result_ch ();

    nec_ir_frame_transmitter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);

    function item_t make_item(logic [1:0] op, logic ll, logic [7:0] lo, logic [7:0] hi,
                              logic [7:0] cmd);
        item_t it;
        it.operation    = op;
        it.long_leader  = ll;
        it.address_low  = lo;
        it.address_high = hi;
        it.command      = cmd;
        return it;
    endfunction

    function item_t random_item(logic [1:0] op);
        return make_item(op, 1'($urandom_range(1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    // entered and left at a falling edge; valid stays up for a back-to-back transfer
    task automatic send_item(item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic drain_levels();
        item_ch.valid <= 1'b0;
        while (sb.pending_levels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_carrier(logic [LVL_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        sb.carrier_top = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        repeat (2) @(negedge clk);
    endtask

    // ticks into the frame, with occasional requests that must be ignored
    task automatic tick_frame(int n, int noise_per_mille);
        repeat (n)
        begin
            if ($urandom_range(999) < noise_per_mille)
                send_item(random_item(2'($urandom_range(1, 3))));
            else
                send_item(random_item(OP_TICK));
        end
    endtask

    task automatic idle_burst(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(2);
            send_item(random_item(r == 0 ? OP_TICK : (r == 1 ? OP_ON : OP_OFF)));
        end
    endtask

    initial
    begin
        int               p;
        logic [LVL_W-1:0] top_val;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        rst_n           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle tick and manual levels
        send_item(make_item(OP_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(OP_ON, 1'b0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(OP_OFF, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(OP_ON, 1'b0, 8'h00, 8'h00, 8'h00));

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    top_val         = 8'($urandom_range(2, 254));
                end
                1:
                begin
                    sender_idle_pct = 60;
                    recv_stall_pct  = 0;
                    top_val         = 8'd255;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 60;
                    top_val         = 8'd1;
                end
                default:
                begin
                    sender_idle_pct = 17;
                    recv_stall_pct  = 17;
                    top_val         = 8'd0;
                end
            endcase
            drain_levels();
            write_carrier(top_val);
            idle_burst(210);
        end

        // long-leader frame start, then requests while busy and ticks into the frame
        drain_levels();
        write_carrier(8'($urandom_range(2, 254)));
        send_item(make_item(OP_START, 1'b1, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(OP_START, 1'b0, 8'h12, 8'h34, 8'h56));
        send_item(make_item(OP_OFF, 1'b0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(OP_ON, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        tick_frame(550, 50);

        drain_levels();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/nec_tx_pkg.sv
hdl/nec_tx_chan_if.sv
hdl/nec_tx_in_stage.sv
hdl/nec_tx_engine.sv
hdl/nec_tx_top.sv
sim/tb.sv
